[hw/rtl/q2e_pkg.sv]
// shared types, widths and the arctangent table for the quaternion to euler converter
package q2e_pkg;

    localparam int PW        = 36;
    localparam int XW        = 38;
    localparam int ZW        = 28;
    localparam int RW        = 58;
    localparam int QW        = 29;
    localparam int MW        = 32;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] PI_ACC = 28'sd16777216;

    typedef struct packed {
        logic signed [PW-1:0] sr;
        logic signed [PW-1:0] cr;
        logic signed [PW-1:0] sy;
        logic signed [PW-1:0] cy;
        logic signed [PW-1:0] sp;
        logic                 clamp_pos;
        logic                 clamp_neg;
    } side_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic zero_roll;
        logic zero_yaw;
        logic clamp_pos;
        logic clamp_neg;
    } tag_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            0:  r = 28'sd4194304;
            1:  r = 28'sd2476042;
            2:  r = 28'sd1308273;
            3:  r = 28'sd664100;
            4:  r = 28'sd333339;
            5:  r = 28'sd166832;
            6:  r = 28'sd83436;
            7:  r = 28'sd41721;
            8:  r = 28'sd20861;
            9:  r = 28'sd10430;
            10: r = 28'sd5215;
            11: r = 28'sd2608;
            12: r = 28'sd1304;
            13: r = 28'sd652;
            14: r = 28'sd326;
            15: r = 28'sd163;
            16: r = 28'sd81;
            17: r = 28'sd41;
            18: r = 28'sd20;
            19: r = 28'sd10;
            20: r = 28'sd5;
            21: r = 28'sd3;
            22: r = 28'sd1;
            23: r = 28'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/q2e_sqrt_cell.sv]
// one digit cell of the pipelined integer square root, carrying the angle operands along
module q2e_sqrt_cell (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [q2e_pkg::MW-1:0]    rem_in,
    input  logic [q2e_pkg::QW-1:0]    root_in,
    input  logic [q2e_pkg::RW-1:0]    rad_in,
    input  q2e_pkg::side_t            side_in,
    output logic [q2e_pkg::MW-1:0]    rem_out,
    output logic [q2e_pkg::QW-1:0]    root_out,
    output logic [q2e_pkg::RW-1:0]    rad_out,
    output q2e_pkg::side_t            side_out
);

    logic [q2e_pkg::MW-1:0] r2;
    logic [q2e_pkg::MW-1:0] trial;
    logic                   ge;
    logic [q2e_pkg::MW-1:0] rem_next;
    logic [q2e_pkg::QW-1:0] root_next;
    logic [q2e_pkg::RW-1:0] rad_next;
    logic [q2e_pkg::MW-1:0] rem_reg;
    logic [q2e_pkg::QW-1:0] root_reg;
    logic [q2e_pkg::RW-1:0] rad_reg;
    q2e_pkg::side_t         side_reg;

    always_comb begin
        r2        = {rem_in[q2e_pkg::MW-3:0], rad_in[q2e_pkg::RW-1 -: 2]};
        trial     = q2e_pkg::MW'({root_in, 2'b01});
        ge        = (r2 >= trial);
        rem_next  = ge ? (r2 - trial) : r2;
        root_next = {root_in[q2e_pkg::QW-2:0], ge};
        rad_next  = {rad_in[q2e_pkg::RW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
    assign side_out = side_reg;

endmodule

[hw/rtl/q2e_cordic_cell.sv]
// one vectoring cordic micro-rotation stage
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  q2e_pkg::vec_t vec_in,
    output q2e_pkg::vec_t vec_out
);

    q2e_pkg::vec_t        vec_next;
    q2e_pkg::vec_t        vec_reg;
    logic signed [q2e_pkg::XW-1:0] dx;
    logic signed [q2e_pkg::XW-1:0] dy;

    always_comb begin
        dx = vec_in.y >>> STAGE;
        dy = vec_in.x >>> STAGE;
        if (!vec_in.y[q2e_pkg::XW-1]) begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + q2e_pkg::atan_entry(STAGE);
        end else begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - q2e_pkg::atan_entry(STAGE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

[hw/rtl/quaternion_to_euler_angles.sv]
// quaternion to roll, pitch and yaw converter, top level
// Takes one unit quaternion in signed Q1.14 per clock and returns roll, pitch and yaw with
// 32768 counts per pi. The path is a fixed pipeline: three stages of products and sums,
// 29 square root digit cells, one quadrant stage, CORDIC_STAGES cordic cells per angle, capped
// at the 24 table entries, and the output register.
// One request is accepted every clock while the result side keeps taking; a stall on the
// result side holds the whole pipeline.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_roll_angle,
    output logic signed [15:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_angle,
    output logic               m_pitch_clamped
);

    localparam int NSTG  = (CORDIC_STAGES < q2e_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                                : q2e_pkg::TABLE_LEN;
    localparam int NSQ   = q2e_pkg::QW;
    localparam int PW    = q2e_pkg::PW;
    localparam int XW    = q2e_pkg::XW;
    localparam int ZW    = q2e_pkg::ZW;

    logic en;

    // products
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    logic               v1_reg;

    // sums
    q2e_pkg::side_t     side_next;
    q2e_pkg::side_t     s2_reg;
    logic               v2_reg;

    // square of the pitch sine
    logic [PW-1:0]      abs_sp;
    logic [55:0]        sq_reg;
    q2e_pkg::side_t     s3_next;
    q2e_pkg::side_t     s3_reg;
    logic               v3_reg;

    logic [q2e_pkg::MW-1:0] rem_a  [NSQ+1];
    logic [q2e_pkg::QW-1:0] root_a [NSQ+1];
    logic [q2e_pkg::RW-1:0] rad_a  [NSQ+1];
    q2e_pkg::side_t         side_a [NSQ+1];
    logic                   vs_reg [NSQ+1];

    q2e_pkg::vec_t roll_a  [NSTG+1];
    q2e_pkg::vec_t pitch_a [NSTG+1];
    q2e_pkg::vec_t yaw_a   [NSTG+1];
    q2e_pkg::vec_t roll_pre, pitch_pre, yaw_pre;
    q2e_pkg::vec_t roll_pre_reg, pitch_pre_reg, yaw_pre_reg;
    q2e_pkg::tag_t tag_pre;
    q2e_pkg::tag_t tag_reg [NSTG+1];
    logic          vc_reg  [NSTG+1];

    logic signed [ZW-1:0] roll_cnt, pitch_cnt, yaw_cnt;
    logic signed [15:0]   roll_next, pitch_next, yaw_next;
    logic                 clamp_next;

    logic                 m_valid_reg;
    logic signed [15:0]   roll_reg, pitch_reg, yaw_reg;
    logic                 clamp_reg;

    function automatic q2e_pkg::vec_t prerot(input logic signed [PW-1:0] ys,
                                             input logic signed [PW-1:0] xs);
        q2e_pkg::vec_t v;
        v.x = XW'(xs);
        v.y = XW'(ys);
        v.z = '0;
        if (xs[PW-1]) begin
            v.z = ys[PW-1] ? -q2e_pkg::PI_ACC : q2e_pkg::PI_ACC;
            v.x = -XW'(xs);
            v.y = -XW'(ys);
        end
        return v;
    endfunction

    function automatic logic signed [ZW-1:0] to_counts(input logic signed [ZW-1:0] acc);
        logic signed [ZW-1:0] t;
        t = acc + ZW'(256);
        return t >>> 9;
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wx_reg <= s_quat_w * s_quat_x;
            p_yz_reg <= s_quat_y * s_quat_z;
            p_xx_reg <= s_quat_x * s_quat_x;
            p_yy_reg <= s_quat_y * s_quat_y;
            p_wy_reg <= s_quat_w * s_quat_y;
            p_zx_reg <= s_quat_z * s_quat_x;
            p_wz_reg <= s_quat_w * s_quat_z;
            p_xy_reg <= s_quat_x * s_quat_y;
            p_zz_reg <= s_quat_z * s_quat_z;
        end
    end

    always_comb begin
        side_next.sr = (PW'(p_wx_reg) + PW'(p_yz_reg)) <<< 1;
        side_next.cr = 36'sd268435456 - ((PW'(p_xx_reg) + PW'(p_yy_reg)) <<< 1);
        side_next.sp = (PW'(p_wy_reg) - PW'(p_zx_reg)) <<< 1;
        side_next.sy = (PW'(p_wz_reg) + PW'(p_xy_reg)) <<< 1;
        side_next.cy = 36'sd268435456 - ((PW'(p_yy_reg) + PW'(p_zz_reg)) <<< 1);
        side_next.clamp_pos = 1'b0;
        side_next.clamp_neg = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= side_next;
        end
    end

    assign abs_sp = s2_reg.sp[PW-1] ? PW'(-s2_reg.sp) : PW'(s2_reg.sp);

    always_comb begin
        s3_next           = s2_reg;
        s3_next.clamp_pos = (s2_reg.sp >= 36'sd268435456);
        s3_next.clamp_neg = (s2_reg.sp <= -36'sd268435456);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= abs_sp[27:0] * abs_sp[27:0];
            s3_reg <= s3_next;
        end
    end

    // square root of one minus the squared sine
    assign rem_a[0]  = '0;
    assign root_a[0] = '0;
    assign rad_a[0]  = (q2e_pkg::RW'(1) << 56) - q2e_pkg::RW'(sq_reg);
    assign side_a[0] = s3_reg;
    assign vs_reg[0] = v3_reg;

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        q2e_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem_a[k]),
            .root_in  (root_a[k]),
            .rad_in   (rad_a[k]),
            .side_in  (side_a[k]),
            .rem_out  (rem_a[k+1]),
            .root_out (root_a[k+1]),
            .rad_out  (rad_a[k+1]),
            .side_out (side_a[k+1])
        );
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[k+1] <= 1'b0;
            end else if (en) begin
                vs_reg[k+1] <= vs_reg[k];
            end
        end
    end

    // quadrant stage
    always_comb begin
        roll_pre  = prerot(side_a[NSQ].sr, side_a[NSQ].cr);
        yaw_pre   = prerot(side_a[NSQ].sy, side_a[NSQ].cy);
        pitch_pre = prerot(side_a[NSQ].sp, PW'(root_a[NSQ]));
        tag_pre.zero_roll = (side_a[NSQ].sr == '0) && (side_a[NSQ].cr == '0);
        tag_pre.zero_yaw  = (side_a[NSQ].sy == '0) && (side_a[NSQ].cy == '0);
        tag_pre.clamp_pos = side_a[NSQ].clamp_pos;
        tag_pre.clamp_neg = side_a[NSQ].clamp_neg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_pre_reg  <= roll_pre;
            pitch_pre_reg <= pitch_pre;
            yaw_pre_reg   <= yaw_pre;
            tag_reg[0]    <= tag_pre;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            vc_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vc_reg[0] <= vs_reg[NSQ];
        end
    end

    assign roll_a[0]  = roll_pre_reg;
    assign pitch_a[0] = pitch_pre_reg;
    assign yaw_a[0]   = yaw_pre_reg;

    for (genvar i = 0; i < NSTG; i++) begin : g_cordic
        q2e_cordic_cell #(.STAGE(i)) u_roll (
            .aclk    (aclk),
            .en      (en),
            .vec_in  (roll_a[i]),
            .vec_out (roll_a[i+1])
        );
        q2e_cordic_cell #(.STAGE(i)) u_pitch (
            .aclk    (aclk),
            .en      (en),
            .vec_in  (pitch_a[i]),
            .vec_out (pitch_a[i+1])
        );
        q2e_cordic_cell #(.STAGE(i)) u_yaw (
            .aclk    (aclk),
            .en      (en),
            .vec_in  (yaw_a[i]),
            .vec_out (yaw_a[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[i+1] <= 1'b0;
            end else if (en) begin
                vc_reg[i+1] <= vc_reg[i];
            end
        end
    end

    // angle scaling and pitch limits
    always_comb begin
        roll_cnt   = to_counts(roll_a[NSTG].z);
        pitch_cnt  = to_counts(pitch_a[NSTG].z);
        yaw_cnt    = to_counts(yaw_a[NSTG].z);
        roll_next  = tag_reg[NSTG].zero_roll ? 16'sd0 : roll_cnt[15:0];
        yaw_next   = tag_reg[NSTG].zero_yaw  ? 16'sd0 : yaw_cnt[15:0];
        clamp_next = tag_reg[NSTG].clamp_pos || tag_reg[NSTG].clamp_neg;
        priority if (tag_reg[NSTG].clamp_pos) begin
            pitch_next = 16'sd16384;
        end else if (tag_reg[NSTG].clamp_neg) begin
            pitch_next = -16'sd16384;
        end else if (pitch_cnt > 28'sd16384) begin
            pitch_next = 16'sd16384;
        end else if (pitch_cnt < -28'sd16384) begin
            pitch_next = -16'sd16384;
        end else begin
            pitch_next = pitch_cnt[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vc_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            clamp_reg <= clamp_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_roll_angle    = roll_reg;
    assign m_pitch_angle   = pitch_reg;
    assign m_yaw_angle     = yaw_reg;
    assign m_pitch_clamped = clamp_reg;

endmodule

[hw/rtl/q2e_checker.sv]
// port level checks for the quaternion to euler converter and their bind
module q2e_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_roll_angle,
    input logic signed [15:0] m_pitch_angle,
    input logic signed [15:0] m_yaw_angle,
    input logic               m_pitch_clamped
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_roll_angle) && $stable(m_pitch_angle)
                                && $stable(m_yaw_angle) && $stable(m_pitch_clamped))
        else $error("result payload changed while stalled");

    a_clamp_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pitch_clamped |->
            (m_pitch_angle == 16'sd16384) || (m_pitch_angle == -16'sd16384))
        else $error("clamped pitch not at half pi");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle <= 16'sd16384) && (m_pitch_angle >= -16'sd16384))
        else $error("pitch outside half pi");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
